// ----- rtl/mme_pkg.sv -----
// mme_pkg: shared constants, command codes, register indexes and the
// control/status structs between the controller and the datapath
// no dependencies
package mme_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;

  // fixed field widths of the channels
  localparam int CMD_W     = 2;
  localparam int FIELD_W   = 3;
  localparam int VALUE_W   = 16;
  localparam int OUT_W     = 35;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // derived sizes
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM + 1) : 1;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int PROD_W  = 2 * ELEM_WIDTH;
  localparam int ACC_W   = (PROD_W > OUT_W) ? PROD_W : OUT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_LEN = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_index_t;

  // controller -> datapath
  typedef struct packed {
    logic             accept_en;
    logic             issue;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } mme_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             compute_req;
    logic             result_taken;
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
  } mme_stat_t;

  // zero counts as one, anything above the array size clamps to it
  function automatic logic [DIM_W-1:0] eff_dim(logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

endpackage

// ----- rtl/mme_if.sv -----
// valid/ready channel interfaces: element/command input, result output,
// configuration write
// depends on mme_pkg
interface mme_in_if import mme_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [FIELD_W-1:0]        row;
  logic [FIELD_W-1:0]        col;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface mme_out_if import mme_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FIELD_W-1:0]      out_row;
  logic [FIELD_W-1:0]      out_col;
  logic signed [OUT_W-1:0] out_value;
  logic                    last;

  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface

interface mme_cfg_if import mme_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mme_ctrl.sv -----
// mme_ctrl: sequencer walking result rows, columns and the inner index
// depends on mme_pkg
module mme_ctrl import mme_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mme_stat_t stat,
  output mme_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] i_r, j_r, k_r;
  logic             k_end, j_end, i_end;

  assign k_end = (DIM_W'(k_r) + DIM_W'(1)) == stat.nk;
  assign j_end = (DIM_W'(j_r) + DIM_W'(1)) == stat.nc;
  assign i_end = (DIM_W'(i_r) + DIM_W'(1)) == stat.nr;

  always_comb begin
    cmd.accept_en = (state_r == ST_IDLE);
    cmd.issue     = (state_r == ST_ISSUE);
    cmd.first     = (k_r == '0);
    cmd.last_k    = k_end;
    cmd.last_elem = i_end && j_end;
    cmd.i         = i_r;
    cmd.j         = j_r;
    cmd.k         = k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (stat.compute_req) begin
            i_r     <= '0;
            j_r     <= '0;
            k_r     <= '0;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_end) begin
            k_r     <= '0;
            state_r <= ST_WAIT;
          end else begin
            k_r <= k_r + IDX_W'(1);
          end
        end
        ST_WAIT: begin
          if (stat.result_taken) begin
            if (j_end) begin
              j_r <= '0;
              if (i_end) begin
                i_r     <= '0;
                state_r <= ST_IDLE;
              end else begin
                i_r     <= i_r + IDX_W'(1);
                state_r <= ST_ISSUE;
              end
            end else begin
              j_r     <= j_r + IDX_W'(1);
              state_r <= ST_ISSUE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mme_datapath.sv -----
// mme_datapath: dimension registers, A/B element memories, multiply and
// accumulate pipeline, output register
// depends on mme_pkg, mme_if
module mme_datapath import mme_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  mme_in_if.sink        in_ch,
  mme_out_if.source     out_ch,
  mme_cfg_if.sink       cfg_ch,
  input  mme_cmd_t      cmd,
  output mme_stat_t     stat
);

  // dimension registers
  logic [CFG_W-1:0] rows_a_r, inner_len_r, cols_b_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= CFG_W'(8);
      inner_len_r <= CFG_W'(8);
      cols_b_r    <= CFG_W'(8);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ROWS_A:    rows_a_r    <= cfg_ch.data;
        REG_INNER_LEN: inner_len_r <= cfg_ch.data;
        REG_COLS_B:    cols_b_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // input side
  logic                  in_acc, in_range, wr_a, wr_b;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;

  assign in_ch.ready = cmd.accept_en;
  assign in_acc   = in_ch.valid && cmd.accept_en;
  assign in_range = ({1'b0, in_ch.row} < (FIELD_W + 1)'(MAX_DIM)) &&
                    ({1'b0, in_ch.col} < (FIELD_W + 1)'(MAX_DIM));
  assign wr_a     = in_acc && in_range && (in_ch.command == CMD_LOAD_A);
  assign wr_b     = in_acc && in_range && (in_ch.command == CMD_LOAD_B);
  assign wr_addr  = {in_ch.row[IDX_W-1:0], in_ch.col[IDX_W-1:0]};
  assign wr_data  = ELEM_WIDTH'($unsigned(in_ch.value));

  // element memories, registered read
  logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_a_r, rd_b_r;
  logic [ADDR_W-1:0]     rd_addr_a, rd_addr_b;

  assign rd_addr_a = {cmd.i, cmd.k};
  assign rd_addr_b = {cmd.k, cmd.j};

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b_r <= mem_b[rd_addr_b];
  end

  // tags following the read stage and the multiply stage
  logic             v1_r, first1_r, lastk1_r, laste1_r;
  logic [IDX_W-1:0] row1_r, col1_r;
  logic             v2_r, first2_r, lastk2_r, laste2_r;
  logic [IDX_W-1:0] row2_r, col2_r;
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cmd.first;
    lastk1_r <= cmd.last_k;
    laste1_r <= cmd.last_elem;
    row1_r   <= cmd.i;
    col1_r   <= cmd.j;
    first2_r <= first1_r;
    lastk2_r <= lastk1_r;
    laste2_r <= laste1_r;
    row2_r   <= row1_r;
    col2_r   <= col1_r;
    prod_r   <= $signed(rd_a_r) * $signed(rd_b_r);
  end

  // accumulate and output register
  logic signed [ACC_W-1:0] prod_ext, acc_r, acc_nxt;
  logic                    out_valid_r, out_last_r;
  logic [FIELD_W-1:0]      out_row_r, out_col_r;
  logic signed [OUT_W-1:0] out_value_r;
  logic                    taken;

  assign prod_ext = ACC_W'(prod_r);
  assign acc_nxt  = first2_r ? prod_ext : (acc_r + prod_ext);
  assign taken    = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
    if (v2_r && lastk2_r) begin
      out_value_r <= acc_nxt[OUT_W-1:0];
      out_row_r   <= FIELD_W'(row2_r);
      out_col_r   <= FIELD_W'(col2_r);
      out_last_r  <= laste2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (v2_r && lastk2_r) begin
      out_valid_r <= 1'b1;
    end else if (taken) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.last      = out_last_r;

  always_comb begin
    stat.compute_req  = in_acc && (in_ch.command == CMD_COMPUTE);
    stat.result_taken = taken;
    stat.nr           = eff_dim(rows_a_r);
    stat.nk           = eff_dim(inner_len_r);
    stat.nc           = eff_dim(cols_b_r);
  end

endmodule

// ----- rtl/matrix_multiply_engine_top.sv -----
// matrix_multiply_engine_top: load items are taken while the sequencer idles;
// a compute item is bound by one shared multiply-accumulate reading one A and
// one B element per cycle while issuing, and waits for each result to be taken
// the first result passes the read, multiply and output registers after issue
// reset (rst_n low, synchronous): dimensions back to 8, sequencer idle,
// pipeline and output empty; element memories keep no reset value
module matrix_multiply_engine_top import mme_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mme_in_if.sink    in_ch,
  mme_out_if.source out_ch,
  mme_cfg_if.sink   cfg_ch
);

  // controller <-> datapath hookup, nothing else crosses
  mme_cmd_t  cmd;
  mme_stat_t stat;

  // sequencer: idles taking loads, then per result element issues nk
  // reads of a row of A and a column of B, then waits for the result
  // to leave the output register before the next element
  mme_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath: memory write on load items, registered reads, multiply,
  // accumulate, and the single output register
  mme_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ----- bench/mme_result_checker.sv -----
// mme_result_checker: watches the element, configuration and result channels,
// predicts every product element and compares it with what the engine emits
// depends on mme_pkg and the channel interfaces in mme_if.sv
`timescale 1ns / 100ps

module mme_result_checker import mme_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mme_in_if    in_mon,
  mme_out_if   out_mon,
  mme_cfg_if   cfg_mon,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [FIELD_W-1:0]      row;
    logic [FIELD_W-1:0]      col;
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } c_elem_t;

  logic [CFG_W-1:0]          rows_reg;
  logic [CFG_W-1:0]          inner_reg;
  logic [CFG_W-1:0]          cols_reg;
  logic signed [VALUE_W-1:0] a_elems [DEPTH];
  logic signed [VALUE_W-1:0] b_elems [DEPTH];
  c_elem_t                   c_elements_due [$];
  int                        mismatches = 0;

  function automatic int dim_in_use(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > CFG_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  // whole product in row-major order, exact sums cut to the result width
  function automatic void push_product_elements();
    int      nr;
    int      nk;
    int      nc;
    longint  acc;
    c_elem_t e;
    nr = dim_in_use(rows_reg);
    nk = dim_in_use(inner_reg);
    nc = dim_in_use(cols_reg);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += longint'(a_elems[i * MAX_DIM + k]) * longint'(b_elems[k * MAX_DIM + j]);
        end
        e.row   = FIELD_W'(i);
        e.col   = FIELD_W'(j);
        e.value = acc[OUT_W-1:0];
        e.last  = (i == nr - 1) && (j == nc - 1);
        c_elements_due.push_back(e);
      end
    end
  endfunction

  always @(posedge clk) begin
    c_elem_t want;
    int      addr;
    if (!rst_n) begin
      rows_reg  = CFG_W'(8);
      inner_reg = CFG_W'(8);
      cols_reg  = CFG_W'(8);
      c_elements_due.delete();
    end else begin
      // results first: one taken this edge cannot stem from a compute taken now
      if (out_mon.valid && out_mon.ready) begin
        if (c_elements_due.size() == 0) begin
          $error("unexpected result: out_row %0d out_col %0d out_value %0d last %0b",
                 out_mon.out_row, out_mon.out_col, out_mon.out_value, out_mon.last);
          mismatches++;
        end else begin
          want = c_elements_due.pop_front();
          if (out_mon.out_row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, out_mon.out_row);
            mismatches++;
          end
          if (out_mon.out_col !== want.col) begin
            $error("out_col: expected %0d, actual %0d", want.col, out_mon.out_col);
            mismatches++;
          end
          if (out_mon.out_value !== want.value) begin
            $error("out_value: expected %0d, actual %0d", want.value, out_mon.out_value);
            mismatches++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_mon.last);
            mismatches++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_ROWS_A:    rows_reg  = cfg_mon.data;
          REG_INNER_LEN: inner_reg = cfg_mon.data;
          REG_COLS_B:    cols_reg  = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        addr = int'(in_mon.row) * MAX_DIM + int'(in_mon.col);
        case (in_mon.command)
          CMD_LOAD_A: begin
            if (in_mon.row < MAX_DIM && in_mon.col < MAX_DIM) a_elems[addr] = in_mon.value;
          end
          CMD_LOAD_B: begin
            if (in_mon.row < MAX_DIM && in_mon.col < MAX_DIM) b_elems[addr] = in_mon.value;
          end
          CMD_COMPUTE: push_product_elements();
          default: ;
        endcase
      end
    end
    errors  <= mismatches;
    pending <= c_elements_due.size();
  end

endmodule

// ----- bench/tb_matrix_multiply_engine_top.sv -----
// tb_matrix_multiply_engine_top: stimulus, reset, idling and verdict for the
// matrix multiply engine; the checking lives in mme_result_checker
// depends on mme_pkg, mme_if.sv, mme_result_checker and the engine rtl
`timescale 1ns / 100ps

module tb_matrix_multiply_engine_top;
  import mme_pkg::*;

  // codes that the package has no name for
  localparam logic [CMD_W-1:0]     CMD_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

  localparam int ITEMS_PER_PHASE = 12;
  localparam int SETTLE_CYCLES   = 16;    // covers one element's issue plus pipeline slack
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no item moving

  logic clk = 1'b0;
  logic rst_n;

  mme_in_if  in_ch ();
  mme_out_if out_ch ();
  mme_cfg_if cfg_ch ();

  int errors;
  int pending;

  // idle rates in percent, changed per phase
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;

  // hold-off requests: raised by stimulus, served by the receiver
  int hold_requests = 0;
  int hold_served   = 0;

  // raw register values last written, and which store entries hold data
  logic [CFG_W-1:0] rows_raw;
  logic [CFG_W-1:0] inner_raw;
  logic [CFG_W-1:0] cols_raw;
  bit               a_loaded [DEPTH];
  bit               b_loaded [DEPTH];

  int quiet_cycles = 0;

  matrix_multiply_engine_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mme_result_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_mon (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: when no handshake moves on any channel, the run ends
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, or one long hold-off when asked for
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= !(snk_stall_pct != 0 && $urandom_range(99) < snk_stall_pct);
      end
    end
  end

  function automatic int dim_in_use(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > CFG_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  // one item on the element channel; valid stays up unless the sender idles
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] row,
                           input logic [FIELD_W-1:0] col, input logic [VALUE_W-1:0] val);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.row     <= row;
    in_ch.col     <= col;
    in_ch.value   <= val;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_LOAD_A) a_loaded[int'(row) * MAX_DIM + int'(col)] = 1'b1;
    if (cmd == CMD_LOAD_B) b_loaded[int'(row) * MAX_DIM + int'(col)] = 1'b1;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // one register write; the caller lowers valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
                          input logic [CFG_W-1:0] c);
    write_reg(REG_ROWS_A, r);
    write_reg(REG_INNER_LEN, k);
    write_reg(REG_COLS_B, c);
    cfg_ch.valid <= 1'b0;
    rows_raw  = r;
    inner_raw = k;
    cols_raw  = c;
  endtask

  // make sure every A and B entry the next compute reads holds data;
  // with overwrite set, all of them get the given fill values
  task automatic prime_operands(input bit overwrite, input logic [VALUE_W-1:0] a_fill,
                                input logic [VALUE_W-1:0] b_fill);
    int nr;
    int nk;
    int nc;
    nr = dim_in_use(rows_raw);
    nk = dim_in_use(inner_raw);
    nc = dim_in_use(cols_raw);
    for (int r = 0; r < nr; r++) begin
      for (int k = 0; k < nk; k++) begin
        if (overwrite || !a_loaded[r * MAX_DIM + k]) begin
          send_item(CMD_LOAD_A, FIELD_W'(r), FIELD_W'(k),
                    overwrite ? a_fill : VALUE_W'($urandom));
        end
      end
    end
    for (int k = 0; k < nk; k++) begin
      for (int c = 0; c < nc; c++) begin
        if (overwrite || !b_loaded[k * MAX_DIM + c]) begin
          send_item(CMD_LOAD_B, FIELD_W'(k), FIELD_W'(c),
                    overwrite ? b_fill : VALUE_W'($urandom));
        end
      end
    end
  endtask

  // stop offering, wait out every expected result, then let the pipeline settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int counted;
    int pick;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_LOAD_A;
    in_ch.row     <= '0;
    in_ch.col     <= '0;
    in_ch.value   <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_ROWS_A;
    cfg_ch.data   <= '0;
    rst_n         <= 1'b0;
    rows_raw  = CFG_W'(8);
    inner_raw = CFG_W'(8);
    cols_raw  = CFG_W'(8);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: index with no register behind it, then 1x1x1 products
    write_reg(REG_UNUSED, 4'hF);
    set_dims(4'd1, 4'd1, 4'd1);
    send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h8000);
    send_item(CMD_LOAD_B, 3'd0, 3'd0, 16'h8000);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);    // most negative squared
    send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
    send_item(CMD_COMPUTE, 3'd7, 3'd7, 16'hFFFF);    // mixed-sign extreme
    send_item(CMD_LOAD_A, 3'd7, 3'd7, 16'hFFFF);     // far corner loads, unused here
    send_item(CMD_LOAD_B, 3'd7, 3'd7, 16'h7FFF);
    send_item(CMD_LOAD_B, 3'd0, 3'd0, 16'hFFFF);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
    send_item(CMD_RESERVED, 3'd7, 3'd7, 16'hFFFF);   // unused command, no result
    send_item(CMD_RESERVED, 3'd0, 3'd0, 16'h0000);
    send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h0000);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);    // zero product

    // zero in every dimension register means one
    drain_results();
    set_dims(4'd0, 4'd0, 4'd0);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);

    // all-ones inner length clamps to 8: largest and smallest sums
    drain_results();
    set_dims(4'd1, 4'hF, 4'd1);
    prime_operands(1'b1, 16'h8000, 16'h8000);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
    prime_operands(1'b1, 16'h8000, 16'h7FFF);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);

    // random phases, each with its own idle pattern and dimensions
    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
          set_dims(4'd2, 4'd3, 4'd4);
        end
        1: begin
          src_idle_pct  = 81;
          snk_stall_pct = 0;
          set_dims(CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(1, 4)),
                   CFG_W'($urandom_range(1, 4)));
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 81;
          set_dims(4'd9, 4'd2, 4'd1);
        end
        default: begin
          src_idle_pct  = 32;
          snk_stall_pct = 32;
          set_dims(4'd0, CFG_W'($urandom_range(1, 4)), 4'hC);
        end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // ignored by the block, not counted
          send_item(CMD_RESERVED, FIELD_W'($urandom), FIELD_W'($urandom),
                    VALUE_W'($urandom));
        end else if (pick < 20) begin
          prime_operands(1'b0, '0, '0);
          send_item(CMD_COMPUTE, FIELD_W'($urandom), FIELD_W'($urandom),
                    VALUE_W'($urandom));
          counted++;
        end else begin
          send_item($urandom_range(1) ? CMD_LOAD_B : CMD_LOAD_A, FIELD_W'($urandom),
                    FIELD_W'($urandom), VALUE_W'($urandom));
          counted++;
        end
      end
    end

    // back-pressure: receiver holds off while multi-element computes keep coming
    drain_results();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    set_dims(4'd2, 4'd2, 4'd4);
    prime_operands(1'b0, '0, '0);
    hold_requests <= hold_requests + 1;
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
    repeat (8) begin
      send_item($urandom_range(1) ? CMD_LOAD_B : CMD_LOAD_A, FIELD_W'($urandom),
                FIELD_W'($urandom), VALUE_W'($urandom));
    end
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);

    drain_results();
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
